FILE: src/sd_card_spi_host_sequencer_core_macros.svh
// ----------------------------------------------------------------------------
// sd card spi host sequencer assertion macros
// concurrent assertion forms used by the sds_back sequencer module
// ----------------------------------------------------------------------------
`ifndef SD_CARD_SPI_HOST_SEQUENCER_CORE_MACROS_SVH
`define SD_CARD_SPI_HOST_SEQUENCER_CORE_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define SDS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define SDS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/sds_pkg.sv
// ----------------------------------------------------------------------------
// sds_pkg
// types and constants shared by the sd card spi host sequencer modules
// ----------------------------------------------------------------------------
package sds_pkg;

    localparam logic [1:0] MODE_INIT = 2'd0;
    localparam logic [1:0] MODE_READ = 2'd1;
    localparam logic [1:0] MODE_XCHG = 2'd2;

    localparam logic [7:0] BYTE_IDLE  = 8'hFF;
    localparam logic [7:0] TOKEN_DATA = 8'hFE;
    localparam logic [7:0] ECHO_CHECK = 8'hAA;

    // one queued input beat
    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  miso_byte;
        logic [31:0] block_number;
        logic [8:0]  byte_offset;
        logic [9:0]  byte_count;
    } t_item;

    // one result beat
    typedef struct packed {
        logic [7:0] mosi_byte;
        logic       send_valid;
        logic       card_selected;
        logic       fast_clock;
        logic [7:0] data_byte;
        logic       data_valid;
        logic       done_res;
        logic       failed;
        logic [2:0] card_kind;
    } t_result;

endpackage

FILE: src/sds_front.sv
// ----------------------------------------------------------------------------
// sds_front
// input stage and two-entry queue in front of the sequencer
// ----------------------------------------------------------------------------
module sds_front
    import sds_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_stall,
    input  t_item i_item,
    output logic  o_valid,
    input  logic  i_stall,
    output t_item o_item
);

    t_item      r_buf [2];
    logic       r_rd;
    logic       r_wr;
    logic [1:0] r_cnt;
    logic       w_push;
    logic       w_pop;

    assign o_stall = (r_cnt == 2'd2);
    assign w_push  = i_valid && !o_stall;
    assign o_valid = (r_cnt != 2'd0);
    assign w_pop   = o_valid && !i_stall;
    assign o_item  = r_buf[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wr <= ~r_wr;
            if (w_pop)  r_rd <= ~r_rd;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
        if (w_push) r_buf[r_wr] <= i_item;
    end

endmodule

FILE: src/sds_back.sv
// ----------------------------------------------------------------------------
// sds_back
// command sequencer: one beat in, one result register out
// ----------------------------------------------------------------------------
`include "sd_card_spi_host_sequencer_core_macros.svh"
module sds_back
    import sds_pkg::*;
#(
    parameter int RESPONSE_POLLS = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_item       i_item,
    output logic        o_valid,
    input  logic        i_stall,
    output t_result     o_res
);

    typedef enum logic [3:0] {
        P_IDLE, P_CLOCKS, P_CMD0, P_CMD8, P_R7, P_V1_APP, P_V1_OP, P_OP_APP,
        P_OP_CMD, P_CMD58, P_OCR, P_CMD16, P_CMD17, P_TOKEN, P_DATA, P_TAIL
    } t_phase;

    t_phase      r_phase,  n_phase;
    logic [2:0]  r_frame,  n_frame;
    logic [9:0]  r_bcnt,   n_bcnt;
    logic [15:0] r_retry,  n_retry;
    logic [3:0]  r_poll,   n_poll;
    logic [5:0]  r_cmd,    n_cmd;
    logic [31:0] r_arg,    n_arg;
    logic [2:0]  r_kind,   n_kind;
    logic [8:0]  r_wstart, n_wstart;
    logic [9:0]  r_wend,   n_wend;
    logic        r_fast,   n_fast;
    logic        r_sel,    n_sel;
    logic [15:0] r_idle_lim, r_op_lim, r_tok_lim;
    logic        r_ovalid;
    t_result     r_res, n_res;
    logic        w_take;
    logic [10:0] w_end;
    logic [3:0]  w_poll;
    logic [7:0]  w_m;
    logic        w_cmdph;

    localparam logic [3:0] POLLS = 4'(RESPONSE_POLLS);

    function automatic logic [7:0] frame_byte(input logic [2:0] k, input logic [5:0] c,
                                              input logic [31:0] a);
        logic [7:0] b;
        case (k)
            3'd0: b = BYTE_IDLE;
            3'd1: b = {2'b01, c};
            3'd2: b = a[31:24];
            3'd3: b = a[23:16];
            3'd4: b = a[15:8];
            3'd5: b = a[7:0];
            default: b = (c == 6'd0) ? 8'h95 : ((c == 6'd8) ? 8'h87 : BYTE_IDLE);
        endcase
        return b;
    endfunction

    assign o_stall = r_ovalid && i_stall;
    assign w_take  = i_valid && !o_stall;
    assign o_valid = r_ovalid;
    assign o_res   = r_res;
    assign w_m     = i_item.miso_byte;
    assign w_poll  = r_poll + 4'd1;
    assign w_end   = {2'b0, i_item.byte_offset} + {1'b0, i_item.byte_count};
    assign w_cmdph = (r_phase == P_CMD0) || (r_phase == P_CMD8) || (r_phase == P_V1_APP)
        || (r_phase == P_V1_OP) || (r_phase == P_OP_APP) || (r_phase == P_OP_CMD)
        || (r_phase == P_CMD58) || (r_phase == P_CMD16) || (r_phase == P_CMD17);

    always_comb begin
        n_phase = r_phase; n_frame = r_frame; n_bcnt = r_bcnt; n_retry = r_retry;
        n_poll = r_poll; n_cmd = r_cmd; n_arg = r_arg; n_kind = r_kind;
        n_wstart = r_wstart; n_wend = r_wend; n_fast = r_fast; n_sel = r_sel;
        n_res = '0;
        // next command (phase, index, argument) and the result beat: send byte, done, failure
        begin : seq
            t_phase      bp;
            logic [5:0]  bc;
            logic [31:0] ba;
            logic        go;
            logic        fin;
            logic        fail;
            logic        snd;
            logic [7:0]  sb;
            go = 1'b0; fin = 1'b0; fail = 1'b0; snd = 1'b0; sb = BYTE_IDLE;
            bp = P_IDLE; bc = 6'd0; ba = 32'd0;
            if (i_item.mode == MODE_INIT) begin
                n_fast = 1'b0; n_kind = 3'd0; n_sel = 1'b0;
                n_phase = P_CLOCKS; n_bcnt = 10'd0; snd = 1'b1;
            end else if (i_item.mode == MODE_READ) begin
                n_wstart = i_item.byte_offset;
                n_wend   = (w_end > 11'd512) ? 10'd512 : w_end[9:0];
                n_sel    = 1'b1;
                go = 1'b1; bp = P_CMD17; bc = 6'd17;
                ba = r_kind[2] ? i_item.block_number : {i_item.block_number[22:0], 9'd0};
            end else if (i_item.mode == MODE_XCHG && r_phase != P_IDLE) begin
                if (w_cmdph) begin
                    if (r_frame < 3'd6) begin
                        n_frame = r_frame + 3'd1; snd = 1'b1;
                        sb = frame_byte(r_frame + 3'd1, r_cmd, r_arg);
                    end else if (r_frame == 3'd6) begin
                        n_frame = 3'd7; n_poll = 4'd0; snd = 1'b1;
                    end else begin
                        n_poll = w_poll;
                        if (w_m == BYTE_IDLE && w_poll < POLLS) begin
                            snd = 1'b1;
                        end else begin
                            unique case (r_phase)
                                P_CMD0: begin
                                    if (w_m == 8'd1) begin
                                        go = 1'b1; bp = P_CMD8; bc = 6'd8; ba = 32'h1AA;
                                    end else if (r_retry == r_idle_lim) begin
                                        fin = 1'b1; fail = 1'b1;
                                    end else begin
                                        n_retry = r_retry + 16'd1; go = 1'b1; bp = P_CMD0;
                                    end
                                end
                                P_CMD8: begin
                                    if (!w_m[2]) begin
                                        n_phase = P_R7; n_bcnt = 10'd0; snd = 1'b1;
                                    end else begin
                                        go = 1'b1; bp = P_V1_APP; bc = 6'd55;
                                    end
                                end
                                P_V1_APP: begin
                                    go = 1'b1; bp = P_V1_OP; bc = 6'd41;
                                end
                                P_V1_OP: begin
                                    if (!w_m[2]) n_kind[0] = 1'b1;
                                    n_retry = 16'd0; go = 1'b1;
                                    if (r_kind[1] || !w_m[2] || r_kind[0]) begin
                                        bp = P_OP_APP; bc = 6'd55;
                                    end else begin
                                        bp = P_OP_CMD; bc = 6'd1;
                                    end
                                end
                                P_OP_APP: begin
                                    go = 1'b1; bp = P_OP_CMD; bc = 6'd41;
                                    ba = r_kind[1] ? 32'h4000_0000 : 32'd0;
                                end
                                P_OP_CMD: begin
                                    if (!w_m[0]) begin
                                        go = 1'b1;
                                        if (r_kind[1]) begin
                                            bp = P_CMD58; bc = 6'd58;
                                        end else begin
                                            bp = P_CMD16; bc = 6'd16; ba = 32'd512;
                                        end
                                    end else if (r_retry == r_op_lim) begin
                                        fin = 1'b1; fail = 1'b1;
                                    end else begin
                                        n_retry = r_retry + 16'd1; go = 1'b1;
                                        if (r_kind[1:0] != 2'd0) begin
                                            bp = P_OP_APP; bc = 6'd55;
                                        end else begin
                                            bp = P_OP_CMD; bc = 6'd1;
                                        end
                                    end
                                end
                                P_CMD58: begin
                                    if (w_m != 8'd0) begin
                                        fin = 1'b1; fail = 1'b1;
                                    end else begin
                                        n_phase = P_OCR; n_bcnt = 10'd0; snd = 1'b1;
                                    end
                                end
                                P_CMD16: begin
                                    fin = 1'b1;
                                    if (w_m != 8'd0) fail = 1'b1;
                                    else n_fast = 1'b1;
                                end
                                default: begin
                                    if (w_m != 8'd0) begin
                                        fin = 1'b1; fail = 1'b1;
                                    end else begin
                                        n_phase = P_TOKEN; n_retry = 16'd0; snd = 1'b1;
                                    end
                                end
                            endcase
                        end
                    end
                end else begin
                    unique case (r_phase)
                        P_CLOCKS: begin
                            n_bcnt = r_bcnt + 10'd1;
                            if (r_bcnt + 10'd1 >= 10'd10) begin
                                n_sel = 1'b1; n_retry = 16'd0; go = 1'b1; bp = P_CMD0;
                            end else snd = 1'b1;
                        end
                        P_R7: begin
                            if (r_bcnt == 10'd2 && !w_m[0]) begin
                                fin = 1'b1; fail = 1'b1;
                            end else if (r_bcnt == 10'd3) begin
                                if (w_m != ECHO_CHECK) begin
                                    fin = 1'b1; fail = 1'b1;
                                end else begin
                                    n_kind[1] = 1'b1; n_retry = 16'd0; go = 1'b1;
                                    bp = P_OP_APP; bc = 6'd55;
                                end
                            end else begin
                                n_bcnt = r_bcnt + 10'd1; snd = 1'b1;
                            end
                        end
                        P_OCR: begin
                            if (r_bcnt == 10'd0 && w_m[6]) n_kind[2] = 1'b1;
                            if (r_bcnt >= 10'd3) begin
                                go = 1'b1; bp = P_CMD16; bc = 6'd16; ba = 32'd512;
                            end else begin
                                n_bcnt = r_bcnt + 10'd1; snd = 1'b1;
                            end
                        end
                        P_TOKEN: begin
                            if (w_m == TOKEN_DATA) begin
                                n_phase = P_DATA; n_bcnt = 10'd0; snd = 1'b1;
                            end else if (r_retry == r_tok_lim) begin
                                fin = 1'b1; fail = 1'b1;
                            end else begin
                                n_retry = r_retry + 16'd1; snd = 1'b1;
                            end
                        end
                        P_DATA: begin
                            if ({1'b0, r_bcnt} >= {2'b0, r_wstart} && r_bcnt < r_wend) begin
                                n_res.data_byte  = w_m;
                                n_res.data_valid = 1'b1;
                            end
                            snd = 1'b1;
                            if (r_bcnt == 10'd511) begin
                                n_phase = P_TAIL; n_bcnt = 10'd0;
                            end else n_bcnt = r_bcnt + 10'd1;
                        end
                        P_TAIL: begin
                            if (r_bcnt >= 10'd2) begin
                                fin = 1'b1;
                            end else begin
                                n_bcnt = r_bcnt + 10'd1; snd = 1'b1;
                                if (r_bcnt == 10'd1) n_sel = 1'b0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            if (go) begin
                n_phase = bp; n_cmd = bc; n_arg = ba; n_frame = 3'd0; n_poll = 4'd0;
                snd = 1'b1; sb = BYTE_IDLE;
            end
            if (fin) begin
                n_sel = 1'b0; n_phase = P_IDLE;
                n_res.done_res = 1'b1; n_res.failed = fail;
            end
            if (snd) begin
                n_res.mosi_byte = sb; n_res.send_valid = 1'b1;
            end
        end
        n_res.card_selected = n_sel;
        n_res.fast_clock    = n_fast;
        n_res.card_kind     = n_kind;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= P_IDLE; r_frame <= '0; r_bcnt <= '0; r_retry <= '0;
            r_poll <= '0; r_cmd <= '0; r_arg <= '0; r_kind <= '0; r_wstart <= '0;
            r_wend <= '0; r_fast <= 1'b0; r_sel <= 1'b0; r_ovalid <= 1'b0;
            r_idle_lim <= 16'd511; r_op_lim <= 16'h7FFF; r_tok_lim <= 16'hFFFF;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    2'd0: r_idle_lim <= i_cfg_data;
                    2'd1: r_op_lim   <= i_cfg_data;
                    2'd2: r_tok_lim  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_take) begin
                r_phase <= n_phase; r_frame <= n_frame; r_bcnt <= n_bcnt;
                r_retry <= n_retry; r_poll <= n_poll; r_cmd <= n_cmd; r_arg <= n_arg;
                r_kind <= n_kind; r_wstart <= n_wstart; r_wend <= n_wend;
                r_fast <= n_fast; r_sel <= n_sel;
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
        if (w_take) r_res <= n_res;
    end

    `SDS_ASSERT_IMP(a_done_idle, i_clk, i_rst_n, r_ovalid && r_res.done_res, !r_res.send_valid && !r_res.card_selected && r_phase == P_IDLE, "done beat must leave the sequencer idle and deselected")
    `SDS_ASSERT_IMP(a_dv_data, i_clk, i_rst_n, r_ovalid && r_res.data_valid, r_phase == P_DATA || r_phase == P_TAIL, "data beat outside the block transfer")
    `SDS_ASSERT_NEXT(a_hold, i_clk, i_rst_n, r_ovalid && i_stall, r_ovalid && $stable(r_res), "stalled result changed")
    `SDS_ASSERT_IMP(a_window, i_clk, i_rst_n, 1'b1, r_wend <= 10'd512, "read window end beyond block")

endmodule

FILE: src/sd_card_spi_host_sequencer_core.sv
// path: each input beat is queued, then its result beat is registered in the sequencer
// throughput: one beat per cycle while the output is not stalled, set by the combinational next-byte decision
// a two-entry queue decouples input from sequencer; the result register holds under stall
// reset (synchronous, active low): idle, card deselected, limits 511, 32767, 65535
// ----------------------------------------------------------------------------
// sd_card_spi_host_sequencer_core
// sd card spi mode host sequencer: init and single-block read, one byte a beat
// ----------------------------------------------------------------------------
module sd_card_spi_host_sequencer_core
    import sds_pkg::*;
#(
    parameter int RESPONSE_POLLS = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_mode,
    input  logic [7:0]  i_miso_byte,
    input  logic [31:0] i_block_number,
    input  logic [8:0]  i_byte_offset,
    input  logic [9:0]  i_byte_count,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_mosi_byte,
    output logic        o_send_valid,
    output logic        o_card_selected,
    output logic        o_fast_clock,
    output logic [7:0]  o_data_byte,
    output logic        o_data_valid,
    output logic        o_done_res,
    output logic        o_failed,
    output logic [2:0]  o_card_kind
);

    t_item   w_in;
    t_item   w_q;
    logic    w_qvalid;
    logic    w_qstall;
    t_result w_res;

    assign w_in.mode         = i_mode;
    assign w_in.miso_byte    = i_miso_byte;
    assign w_in.block_number = i_block_number;
    assign w_in.byte_offset  = i_byte_offset;
    assign w_in.byte_count   = i_byte_count;

    sds_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_item(w_in),
        .o_valid(w_qvalid), .i_stall(w_qstall), .o_item(w_q)
    );

    sds_back #(.RESPONSE_POLLS(RESPONSE_POLLS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_valid(w_qvalid), .o_stall(w_qstall), .i_item(w_q),
        .o_valid(o_valid), .i_stall(i_stall), .o_res(w_res)
    );

    assign o_mosi_byte     = w_res.mosi_byte;
    assign o_send_valid    = w_res.send_valid;
    assign o_card_selected = w_res.card_selected;
    assign o_fast_clock    = w_res.fast_clock;
    assign o_data_byte     = w_res.data_byte;
    assign o_data_valid    = w_res.data_valid;
    assign o_done_res      = w_res.done_res;
    assign o_failed        = w_res.failed;
    assign o_card_kind     = w_res.card_kind;

endmodule
